// ===== sv/sst_pkg.sv =====
// Package for the small set table: sizes, widths and operation codes.
`default_nettype none
package sst_pkg;

    localparam int CAPACITY    = 128;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int VALUE_W     = 32;
    localparam int OP_W        = 2;
    localparam int POS_W       = 8;
    localparam int OUT_FIELD_W = 1 + POS_W + POS_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_FIND   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SCAN_RD  = 6'b000010,
        ST_SCAN_CMP = 6'b000100,
        ST_SHIFT_RD = 6'b001000,
        ST_SHIFT_WR = 6'b010000,
        ST_DONE     = 6'b100000
    } state_t;

    localparam logic [POS_W-1:0] NO_POSITION = {POS_W{1'b1}};

endpackage
`default_nettype wire

// ===== sv/small_set_table.sv =====
// Small set table: bounded set of distinct values with find, add, remove and clear.
// Clear goes straight to done; find and add read and compare each held entry in turn.
// Remove scans likewise, then moves each later entry down one place, reading then writing it.
// One item at a time: the scan and the compaction share one compare and one memory port.
// A result waits in the output register while the next item is taken.
// Reset clears the element count and the control state; element storage is not cleared.
`default_nettype none
module small_set_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [sst_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] value
    input  wire logic [sst_pkg::OP_W-1:0]      s_tuser,   // [1:0] operation
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [0] ok, [8:1] position, [16:9] element_count, [17] full_refused, rest zero
    output logic [sst_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import sst_pkg::*;

    logic [VALUE_W-1:0] mem [CAPACITY];

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ok_reg, ok_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               full_reg, full_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [VALUE_W-1:0] rd_data_reg;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [CNT_W-1:0]   idx_inc;

    assign idx_inc  = CNT_W'(idx_reg) + CNT_W'(1);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        value_next   = value_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        ok_next      = ok_reg;
        pos_next     = pos_reg;
        full_next    = full_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = rd_data_reg;
        rd_addr      = idx_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = op_t'(s_tuser);
                    value_next = s_tdata;
                    idx_next   = '0;
                    ok_next    = 1'b0;
                    pos_next   = NO_POSITION;
                    full_next  = 1'b0;
                    if (op_t'(s_tuser) == OP_CLEAR)
                    begin
                        count_next = '0;
                        ok_next    = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        // empty set: absent at once
                        if (op_t'(s_tuser) == OP_ADD)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_data    = s_tdata;
                            pos_next   = '0;
                            count_next = CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end

            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CMP;
            end

            ST_SCAN_CMP:
            begin
                if (rd_data_reg == value_reg)
                begin
                    pos_next = POS_W'(idx_reg);
                    case (op_reg)
                        OP_FIND:
                        begin
                            ok_next    = 1'b1;
                            state_next = ST_DONE;
                        end
                        OP_ADD:
                        begin
                            ok_next    = 1'b0;
                            state_next = ST_DONE;
                        end
                        OP_REMOVE:
                        begin
                            ok_next    = 1'b1;
                            state_next = ST_SHIFT_RD;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
                else if (idx_inc >= count_reg)
                begin
                    // scan ran off the held entries: value absent
                    if (op_reg == OP_ADD)
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = IDX_W'(count_reg);
                            wr_data    = value_reg;
                            pos_next   = POS_W'(count_reg);
                            count_next = count_reg + CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = IDX_W'(idx_inc);
                    state_next = ST_SCAN_RD;
                end
            end

            ST_SHIFT_RD:
            begin
                if (idx_inc < count_reg)
                begin
                    rd_addr    = IDX_W'(idx_inc);
                    state_next = ST_SHIFT_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
            end

            ST_SHIFT_WR:
            begin
                // move the later entry down one place
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = rd_data_reg;
                idx_next   = IDX_W'(idx_inc);
                state_next = ST_SHIFT_RD;
            end

            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_TDATA_W'({full_reg, POS_W'(count_reg), pos_reg, ok_reg});
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        value_reg  <= value_next;
        idx_reg    <= idx_next;
        ok_reg     <= ok_next;
        pos_reg    <= pos_next;
        full_reg   <= full_next;
        m_data_reg <= m_data_next;
    end

endmodule
`default_nettype wire
